### rtl/core/mm_pkg.sv
// Shared types, constants and width helpers for the matrix multiply block.
// Depends on nothing; mm_regs, mm_front, mm_back and matrix_multiply import it.
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MaxDimDefault     = 8;
  localparam int ValueWidthDefault = 32;

  localparam int DimW      = 4;
  localparam int IdxW      = 3;
  localparam int DataW     = 32;
  localparam int PaddrW    = 5;
  localparam int CountW    = 8;
  localparam int CmdDepth  = 4;
  localparam int OutDepth  = 2;
  localparam int CmdKindW  = 2;
  localparam int RegIdxW   = 3;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpStart = 1'b1;

  localparam logic [RegIdxW-1:0] RegARows  = 3'd0;
  localparam logic [RegIdxW-1:0] RegACols  = 3'd1;
  localparam logic [RegIdxW-1:0] RegBRows  = 3'd2;
  localparam logic [RegIdxW-1:0] RegBCols  = 3'd3;
  localparam logic [RegIdxW-1:0] RegAValid = 3'd4;
  localparam logic [RegIdxW-1:0] RegBValid = 3'd5;

  typedef enum logic [CmdKindW-1:0] {
    CmdWriteA,
    CmdWriteB,
    CmdStart,
    CmdStartErr
  } mm_cmd_e;

  typedef struct packed {
    logic              op;
    logic signed [31:0] value;
  } mm_in_t;

  typedef struct packed {
    logic signed [31:0]  product;
    logic [IdxW-1:0]     row_index;
    logic [IdxW-1:0]     col_index;
    logic                result_valid;
    logic                last;
  } mm_out_t;

  typedef struct packed {
    logic [DimW-1:0] a_rows;
    logic [DimW-1:0] a_cols;
    logic [DimW-1:0] b_rows;
    logic [DimW-1:0] b_cols;
    logic            a_valid;
    logic            b_valid;
  } mm_cfg_t;

  // Stored elements never carry more than the 32 bits of the input field.
  function automatic int elem_width(int value_width);
    return (value_width < 32) ? value_width : 32;
  endfunction

  function automatic int addr_width(int max_dim);
    return (max_dim * max_dim > 1) ? $clog2(max_dim * max_dim) : 1;
  endfunction

endpackage

### rtl/core/mm_regs.sv
// Configuration registers behind the APB-style port.
// Depends on mm_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module mm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mm_pkg::PaddrW-1:0] paddr,
  input  logic [mm_pkg::DataW-1:0]  pwdata,
  output logic [mm_pkg::DataW-1:0]  prdata,
  output logic                      pready,
  output mm_pkg::mm_cfg_t           cfg_o
);
  import mm_pkg::*;

  mm_cfg_t              cfg_q, cfg_d;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PaddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegARows:  cfg_d.a_rows  = pwdata[DimW-1:0];
        RegACols:  cfg_d.a_cols  = pwdata[DimW-1:0];
        RegBRows:  cfg_d.b_rows  = pwdata[DimW-1:0];
        RegBCols:  cfg_d.b_cols  = pwdata[DimW-1:0];
        RegAValid: cfg_d.a_valid = pwdata[0];
        RegBValid: cfg_d.b_valid = pwdata[0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegARows:  prdata = DataW'(cfg_q.a_rows);
      RegACols:  prdata = DataW'(cfg_q.a_cols);
      RegBRows:  prdata = DataW'(cfg_q.b_rows);
      RegBCols:  prdata = DataW'(cfg_q.b_cols);
      RegAValid: prdata = DataW'(cfg_q.a_valid);
      RegBValid: prdata = DataW'(cfg_q.b_valid);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows  <= DimW'(1);
      cfg_q.a_cols  <= DimW'(1);
      cfg_q.b_rows  <= DimW'(1);
      cfg_q.b_cols  <= DimW'(1);
      cfg_q.a_valid <= 1'b1;
      cfg_q.b_valid <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/mm_fifo.sv
// Small first-in first-out queue built from flip-flops.
// Depends on nothing beyond its width and depth parameters.
`timescale 1ns / 1ps

module mm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/mm_front.sv
// Front end: accepts requests, keeps the load counter and turns each start into a
// start or error command and each in-range load into a store write. Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_front #(
  parameter int MAX_DIM     = mm_pkg::MaxDimDefault,
  parameter int VALUE_WIDTH = mm_pkg::ValueWidthDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mm_pkg::mm_cfg_t                        cfg_i,
  input  logic                                   push_i,
  input  mm_pkg::mm_in_t                         in_item_i,
  output logic                                   full_o,
  output logic                                   cmd_push_o,
  output logic [mm_pkg::CmdKindW + mm_pkg::addr_width(MAX_DIM) +
                mm_pkg::elem_width(VALUE_WIDTH) - 1:0] cmd_o,
  input  logic                                   cmd_full_i
);
  import mm_pkg::*;

  localparam int ElemW      = elem_width(VALUE_WIDTH);
  localparam int AddrW      = addr_width(MAX_DIM);
  localparam int StoreDepth = MAX_DIM * MAX_DIM;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] na, nb, boff;
  logic              accept, in_a, in_b, keep_a, keep_b, ok;
  mm_cmd_e           kind;
  logic [AddrW-1:0]  addr;

  function automatic logic dim_ok(logic [DimW-1:0] d);
    return (d != '0) && (d <= DimW'(MAX_DIM));
  endfunction

  assign accept = push_i & ~cmd_full_i;
  assign full_o = cmd_full_i;

  assign na     = {{(CountW-DimW){1'b0}}, cfg_i.a_rows} * {{(CountW-DimW){1'b0}}, cfg_i.a_cols};
  assign nb     = {{(CountW-DimW){1'b0}}, cfg_i.b_rows} * {{(CountW-DimW){1'b0}}, cfg_i.b_cols};
  assign boff   = cnt_q - na;
  assign in_a   = (cnt_q < na);
  assign in_b   = !in_a && (boff < nb);
  assign keep_a = in_a && (cnt_q < CountW'(StoreDepth));
  assign keep_b = in_b && (boff < CountW'(StoreDepth));

  assign ok = cfg_i.a_valid && cfg_i.b_valid && (cfg_i.a_cols == cfg_i.b_rows) &&
              dim_ok(cfg_i.a_rows) && dim_ok(cfg_i.a_cols) &&
              dim_ok(cfg_i.b_rows) && dim_ok(cfg_i.b_cols);

  always_comb begin
    if (in_item_i.op == OpStart) begin
      kind = ok ? CmdStart : CmdStartErr;
      addr = '0;
    end else if (in_a) begin
      kind = CmdWriteA;
      addr = AddrW'(cnt_q);
    end else begin
      kind = CmdWriteB;
      addr = AddrW'(boff);
    end
  end

  assign cmd_o      = {kind, addr, in_item_i.value[ElemW-1:0]};
  assign cmd_push_o = accept && ((in_item_i.op == OpStart) || keep_a || keep_b);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_item_i.op == OpStart) begin
        cnt_d = '0;
      end else if (cnt_q != {CountW{1'b1}}) begin
        cnt_d = cnt_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/core/mm_back.sv
// Back end: holds both operand stores, carries out queued writes, answers a failed
// start with an error result and runs the multiply-accumulate walk for each product element. Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_back #(
  parameter int MAX_DIM     = mm_pkg::MaxDimDefault,
  parameter int VALUE_WIDTH = mm_pkg::ValueWidthDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mm_pkg::mm_cfg_t                        cfg_i,
  input  logic                                   cmd_empty_i,
  input  logic [mm_pkg::CmdKindW + mm_pkg::addr_width(MAX_DIM) +
                mm_pkg::elem_width(VALUE_WIDTH) - 1:0] cmd_i,
  output logic                                   cmd_pop_o,
  input  logic                                   out_full_i,
  output logic                                   out_push_o,
  output mm_pkg::mm_out_t                        out_o
);
  import mm_pkg::*;

  localparam int ElemW      = elem_width(VALUE_WIDTH);
  localparam int AddrW      = addr_width(MAX_DIM);
  localparam int StoreDepth = MAX_DIM * MAX_DIM;
  localparam int CmdW       = CmdKindW + AddrW + ElemW;
  localparam int ProdW      = 2 * ElemW;
  localparam int AccW       = (ProdW + 4 > 48) ? ProdW + 4 : 48;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SIssue = 2'd1;
  localparam logic [1:0] SWait  = 2'd2;

  logic signed [ElemW-1:0] a_mem [StoreDepth];
  logic signed [ElemW-1:0] b_mem [StoreDepth];

  logic [1:0]              state_q, state_d;
  logic [IdxW-1:0]         i_q, i_d, j_q, j_d, k_q, k_d;
  logic [AddrW-1:0]        a_row_q, a_row_d, a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic                    v1_q, first1_q, last1_q;
  logic                    v2_q, first2_q, last2_q;
  logic                    done_q;
  logic signed [ElemW-1:0] a_rd_q, b_rd_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_base;

  mm_cmd_e                 cmd_kind;
  logic [AddrW-1:0]        cmd_addr;
  logic [ElemW-1:0]        cmd_data;
  logic                    a_we, b_we, issue, last_k, last_i, last_j;
  logic                    fits;
  logic [AccW-48:0]        acc_top;
  logic signed [31:0]      sat;

  assign cmd_kind = mm_cmd_e'(cmd_i[CmdW-1 -: CmdKindW]);
  assign cmd_addr = cmd_i[ElemW +: AddrW];
  assign cmd_data = cmd_i[ElemW-1:0];

  assign last_k = (DimW'(k_q) == cfg_i.a_cols - DimW'(1));
  assign last_i = (DimW'(i_q) == cfg_i.a_rows - DimW'(1));
  assign last_j = (DimW'(j_q) == cfg_i.b_cols - DimW'(1));

  assign acc_top = acc_q[AccW-1:47];
  assign fits    = (&acc_top) | ~(|acc_top);
  assign sat     = fits ? acc_q[47:16] :
                   (acc_q[AccW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    a_row_d    = a_row_q;
    a_addr_d   = a_addr_q;
    b_addr_d   = b_addr_q;
    cmd_pop_o  = 1'b0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    issue      = 1'b0;
    out_push_o = 1'b0;
    out_o      = '0;

    case (state_q)
      SIdle: begin
        if (!cmd_empty_i) begin
          case (cmd_kind)
            CmdWriteA: begin
              cmd_pop_o = 1'b1;
              a_we      = 1'b1;
            end
            CmdWriteB: begin
              cmd_pop_o = 1'b1;
              b_we      = 1'b1;
            end
            CmdStart: begin
              cmd_pop_o = 1'b1;
              i_d       = '0;
              j_d       = '0;
              k_d       = '0;
              a_row_d   = '0;
              a_addr_d  = '0;
              b_addr_d  = '0;
              state_d   = SIssue;
            end
            CmdStartErr: begin
              if (!out_full_i) begin
                cmd_pop_o        = 1'b1;
                out_push_o       = 1'b1;
                out_o.result_valid = 1'b0;
                out_o.last       = 1'b1;
              end
            end
            default: begin
              cmd_pop_o = 1'b0;
            end
          endcase
        end
      end
      SIssue: begin
        // A new element starts only when its result is sure to find room.
        if (k_q != '0 || !out_full_i) begin
          issue    = 1'b1;
          k_d      = k_q + IdxW'(1);
          a_addr_d = a_addr_q + AddrW'(1);
          b_addr_d = b_addr_q + AddrW'(cfg_i.b_cols);
          if (last_k) begin
            k_d     = '0;
            state_d = SWait;
          end
        end
      end
      SWait: begin
        if (done_q) begin
          out_push_o         = 1'b1;
          out_o.product      = sat;
          out_o.row_index    = i_q;
          out_o.col_index    = j_q;
          out_o.result_valid = 1'b1;
          out_o.last         = last_i && last_j;
          if (last_i && last_j) begin
            state_d = SIdle;
          end else begin
            state_d = SIssue;
            if (last_j) begin
              i_d      = i_q + IdxW'(1);
              j_d      = '0;
              a_row_d  = a_row_q + AddrW'(cfg_i.a_cols);
              a_addr_d = a_row_q + AddrW'(cfg_i.a_cols);
              b_addr_d = '0;
            end else begin
              j_d      = j_q + IdxW'(1);
              a_addr_d = a_row_q;
              b_addr_d = AddrW'(j_q) + AddrW'(1);
            end
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign acc_base = first2_q ? '0 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      a_row_q  <= '0;
      a_addr_q <= '0;
      b_addr_q <= '0;
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      a_row_q  <= a_row_d;
      a_addr_q <= a_addr_d;
      b_addr_q <= b_addr_d;
      v1_q     <= issue;
      first1_q <= (k_q == '0);
      last1_q  <= last_k;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      done_q   <= v2_q & last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[cmd_addr] <= cmd_data;
    end
    if (b_we) begin
      b_mem[cmd_addr] <= cmd_data;
    end
    a_rd_q <= a_mem[a_addr_q];
    b_rd_q <= b_mem[b_addr_q];
    prod_q <= a_rd_q * b_rd_q;
    if (v2_q) begin
      acc_q <= acc_base + AccW'(prod_q);
    end
  end

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result written into a full output queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == SIdle))
    else $error("command taken while a multiply is running");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == SWait))
    else $error("accumulation finished outside the wait state");

  a_issue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last_k) |=> (state_q == SWait) && !issue)
    else $error("issue continued past the last term");

endmodule

### rtl/core/matrix_multiply.sv
// Matrix multiply top level: APB registers, request front end, command queue,
// multiply back end and result queue. Depends on mm_pkg and all mm_* modules.
// A start produces one element at a time through the single multiply-accumulate
// pipeline (store read, multiply, add), issuing the next after a result is written.
// Reset (rst_ni, asynchronous): registers return to 1, queues empty, stores undefined.
`timescale 1ns / 1ps

module matrix_multiply #(
  parameter int MAX_DIM     = mm_pkg::MaxDimDefault,
  parameter int VALUE_WIDTH = mm_pkg::ValueWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mm_pkg::PaddrW-1:0] paddr,
  input  logic [mm_pkg::DataW-1:0]  pwdata,
  output logic [mm_pkg::DataW-1:0]  prdata,
  output logic                      pready,
  input  logic                      push,
  input  mm_pkg::mm_in_t            in_item_i,
  output logic                      full,
  output logic                      empty,
  input  logic                      pop,
  output mm_pkg::mm_out_t           out_item_o
);
  import mm_pkg::*;

  localparam int CmdW = CmdKindW + addr_width(MAX_DIM) + elem_width(VALUE_WIDTH);
  localparam int OutW = $bits(mm_out_t);

  mm_cfg_t          cfg;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CmdW-1:0]  cmd_wdata, cmd_rdata;
  logic             out_push, out_full;
  mm_out_t          out_wdata;
  logic [OutW-1:0]  out_rdata;

  mm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mm_front #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wdata),
    .cmd_full_i (cmd_full)
  );

  mm_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  mm_back #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rdata),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (out_wdata)
  );

  mm_fifo #(
    .WIDTH (OutW),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_item_o = mm_out_t'(out_rdata);

endmodule
